[rtl/core/ssst_pkg.sv]
package ssst_pkg;

    // Largest store the row of cells is built for, and the width of the fill count.
    localparam int CAPACITY_MAX = 64;
    localparam int COUNT_W      = 7;
    localparam int VALUE_W      = 32;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_LOOKUP  = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_ITERATE = 3'd4
    } command_t;

    typedef enum logic [3:0] {
        ST_INSERTED    = 4'd0,
        ST_DUPLICATE   = 4'd1,
        ST_FULL        = 4'd2,
        ST_REMOVED     = 4'd3,
        ST_NOT_PRESENT = 4'd4,
        ST_FOUND       = 4'd5,
        ST_ABSENT      = 4'd6,
        ST_CLEARED     = 4'd7,
        ST_ELEMENT     = 4'd8,
        ST_EMPTY       = 4'd9
    } status_t;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [VALUE_W-1:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic [3:0]                status;
        logic signed [VALUE_W-1:0] element_value;
        logic [COUNT_W-1:0]        element_count;
        logic                      last;
    } rsp_beat_t;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic capture;     // register this cell's compare result
        logic load_tail;   // the cell at the fill position takes the stored key
        logic load_match;  // the matching cell takes the last entry's value
        logic rotate;      // occupied cells pass their value one place towards slot 0
    } cell_ctl_t;

endpackage

[rtl/core/small_set_store_top.sv]
// A set of up to CAPACITY distinct signed 32-bit values, held one to a cell in a row of cells
// with a fill count. Each command beat is compared against every occupied cell in the cycle it
// is accepted. For insert, remove, lookup and clear the update and its single response beat
// follow from the execute state once the response register is free. Iterate on an empty store
// gives one empty beat; otherwise, each time the response register is free, the occupied cells
// rotate one place towards slot 0 and slot 0 is sent out, and after as many steps as there are
// elements the row is back in its original order. An unused command code is accepted and gives
// no response. Back-pressure on the response side holds the sequencer; the response register
// lets a new command beat be taken while the previous response still waits.
module small_set_store_top #(
    parameter int CAPACITY = ssst_pkg::CAPACITY_MAX
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ssst_pkg::cmd_beat_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ssst_pkg::rsp_beat_t rsp
);

    localparam int CW = ssst_pkg::COUNT_W;
    localparam int VW = ssst_pkg::VALUE_W;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_ITER = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              command_reg, command_next;
    logic signed [VW-1:0]    key_reg, key_next;
    logic                    found_reg, found_next;
    logic signed [VW-1:0]    last_val_reg, last_val_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           iter_reg, iter_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    ssst_pkg::rsp_beat_t     rsp_reg, rsp_next;

    ssst_pkg::cell_ctl_t     ctl;
    logic signed [VW-1:0]    cell_value [CAPACITY];
    logic signed [VW-1:0]    cell_last  [CAPACITY];
    logic [CAPACITY-1:0]     match_vec;
    logic signed [VW-1:0]    last_any;
    logic                    out_free;
    logic                    accept;
    logic                    iter_last;
    logic                    emit;
    logic [3:0]              emit_status;
    logic signed [VW-1:0]    emit_value;
    logic                    emit_last;

    // The row of cells; each hands its value to the cell below when rotating.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ssst_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .count       (count_reg),
            .compare_key (cmd.value),
            .store_key   (key_reg),
            .ctl         (ctl),
            .last_value  (last_val_reg),
            .next_value  (cell_value[(i + 1) % CAPACITY]),
            .first_value (cell_value[0]),
            .value       (cell_value[i]),
            .match       (match_vec[i]),
            .last_part   (cell_last[i])
        );
    end

    // Only the last occupied cell drives its value, the others drive zero, so an OR collects it.
    always_comb
    begin
        last_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            last_any = last_any | cell_last[i];
        end
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign accept    = cmd_valid && cmd_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign iter_last = iter_reg == (count_reg - CW'(1));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next    = state_reg;
        command_next  = command_reg;
        key_next      = key_reg;
        found_next    = found_reg;
        last_val_next = last_val_reg;
        count_next    = count_reg;
        iter_next     = iter_reg;
        ctl           = '0;
        emit          = 1'b0;
        emit_status   = ssst_pkg::ST_CLEARED;
        emit_value    = '0;
        emit_last     = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                ctl.capture = accept;
                if (accept)
                begin
                    command_next  = cmd.command;
                    key_next      = cmd.value;
                    found_next    = |match_vec;
                    last_val_next = last_any;
                    if (cmd.command <= ssst_pkg::CMD_ITERATE)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    case (command_reg)
                        ssst_pkg::CMD_INSERT:
                        begin
                            if (found_reg)
                            begin
                                emit_status = ssst_pkg::ST_DUPLICATE;
                            end
                            else if (count_reg >= CAP_COUNT)
                            begin
                                emit_status = ssst_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.load_tail = 1'b1;
                                count_next    = count_reg + CW'(1);
                                emit_status   = ssst_pkg::ST_INSERTED;
                            end
                        end
                        ssst_pkg::CMD_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                ctl.load_match = 1'b1;
                                count_next     = count_reg - CW'(1);
                                emit_status    = ssst_pkg::ST_REMOVED;
                            end
                            else
                            begin
                                emit_status = ssst_pkg::ST_NOT_PRESENT;
                            end
                        end
                        ssst_pkg::CMD_LOOKUP:
                        begin
                            emit_status = found_reg ? ssst_pkg::ST_FOUND : ssst_pkg::ST_ABSENT;
                        end
                        ssst_pkg::CMD_CLEAR:
                        begin
                            count_next  = '0;
                            emit_status = ssst_pkg::ST_CLEARED;
                        end
                        ssst_pkg::CMD_ITERATE:
                        begin
                            if (count_reg == '0)
                            begin
                                emit_status = ssst_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                emit       = 1'b0;
                                iter_next  = '0;
                                state_next = S_ITER;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end

            S_ITER:
            begin
                if (out_free)
                begin
                    ctl.rotate  = 1'b1;
                    emit        = 1'b1;
                    emit_status = ssst_pkg::ST_ELEMENT;
                    emit_value  = cell_value[0];
                    emit_last   = iter_last;
                    iter_next   = iter_reg + CW'(1);
                    if (iter_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register: a new beat is loaded only when the slot is free.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.status        = emit_status;
            rsp_next.element_value = emit_value;
            rsp_next.element_count = count_next;
            rsp_next.last          = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iter_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            iter_reg      <= iter_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg  <= command_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        last_val_reg <= last_val_next;
        rsp_reg      <= rsp_next;
    end

    // The fill count never passes the size of the row.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("fill count above capacity");

    // Stored values are distinct, so at most one occupied cell can match a key.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches");

    // While iterating, the step counter stays below the fill count.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ITER |-> iter_reg < count_reg)
        else $error("iteration step beyond fill count");

    // The final element of an iteration returns the sequencer to idle.
    a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER && out_free && iter_last) |=> state_reg == S_IDLE)
        else $error("iteration did not finish");

endmodule

[rtl/core/ssst_cell.sv]
// One slot of the store. The cell knows its own position, so it works out
// locally whether it is occupied, the fill position or the last occupied slot.
module ssst_cell #(
    parameter int INDEX = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ssst_pkg::COUNT_W-1:0]          count,
    input  logic signed [ssst_pkg::VALUE_W-1:0]   compare_key,
    input  logic signed [ssst_pkg::VALUE_W-1:0]   store_key,
    input  ssst_pkg::cell_ctl_t                   ctl,
    input  logic signed [ssst_pkg::VALUE_W-1:0]   last_value,
    input  logic signed [ssst_pkg::VALUE_W-1:0]   next_value,
    input  logic signed [ssst_pkg::VALUE_W-1:0]   first_value,
    output logic signed [ssst_pkg::VALUE_W-1:0]   value,
    output logic                                  match,
    output logic signed [ssst_pkg::VALUE_W-1:0]   last_part
);

    localparam logic [ssst_pkg::COUNT_W-1:0] MY_POS   = ssst_pkg::COUNT_W'(INDEX);
    localparam logic [ssst_pkg::COUNT_W-1:0] MY_COUNT = ssst_pkg::COUNT_W'(INDEX + 1);

    logic signed [ssst_pkg::VALUE_W-1:0] value_reg;
    logic signed [ssst_pkg::VALUE_W-1:0] value_next;
    logic                                match_reg;
    logic                                occupied;
    logic                                is_tail;
    logic                                is_last;

    assign occupied  = MY_POS < count;
    assign is_tail   = count == MY_POS;
    assign is_last   = count == MY_COUNT;
    assign match     = occupied && (value_reg == compare_key);
    assign last_part = is_last ? value_reg : '0;
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load_tail && is_tail)
        begin
            value_next = store_key;
        end
        else if (ctl.load_match && match_reg)
        begin
            value_next = last_value;
        end
        else if (ctl.rotate && occupied)
        begin
            value_next = is_last ? first_value : next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= match;
        end
    end

endmodule

[tb/tb_small_set_store_top.sv]
// Self-checking bench for small_set_store_top.
//
// A set model kept in the bench follows every command beat that the block accepts. From that
// model it works out the response beats the block owes. The checker process compares each
// accepted response beat, field by field, with the oldest beat still owed.
//
// The bench runs in four stages. Short directed tests come first: the empty store, and the
// extreme values, covering every operation and the three spare command codes. Next the store
// is filled to capacity under a long receiver hold-off. Last comes a long random mix, biased
// towards values that are already stored so that duplicates, hits and removals happen often.
// Both sides idle at random, with quiet stretches in between. The run fails on a mismatch, on
// a response beat that nobody asked for, on beats still owed at the end, or on the cycle limit.
module tb_small_set_store_top;

    localparam int CAP            = ssst_pkg::CAPACITY_MAX;
    localparam int RSP_HOLD_LEN   = 150;    // cycles of the long receiver hold-off
    localparam int SETTLE_CYCLES  = 20;     // quiet time after the last owed beat
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 190;

    // Codes the block must take and drop without any response.
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    localparam logic signed [ssst_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ssst_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                rst_n     = 1'b0;
    logic                clk       = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    ssst_pkg::cmd_beat_t cmd       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    ssst_pkg::rsp_beat_t rsp;

    // The bench's own copy of the set, updated when each command beat is accepted.
    logic signed [ssst_pkg::VALUE_W-1:0] held_values [CAP];
    int                                  held_count = 0;

    // Response beats owed by the block, oldest first.
    ssst_pkg::rsp_beat_t pending_rsps [$];
    ssst_pkg::rsp_beat_t oldest_rsp;

    int   mismatch_count = 0;
    int   cycle_count    = 0;

    // Idle ranges for each side. A test sets them to zero for a stretch with no idling.
    int   cmd_gap_max    = 5;
    int   rsp_stall_max  = 5;

    // The long hold-off is counted in its own process. rsp_held changes only at falling edges.
    event rsp_hold_go;
    logic rsp_held = 1'b0;

    small_set_store_top #(
        .CAPACITY (CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // A hard stop, so that a hung handshake cannot keep the run going for ever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Slot of a value in the bench's set, or -1 when the value is not held.
    function automatic int slot_of(input logic signed [ssst_pkg::VALUE_W-1:0] val);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_values[i] == val)
                return i;
        end
        return -1;
    endfunction

    // Applies one accepted command to the bench's set and queues the beats the block now owes.
    task automatic apply_set_command(input ssst_pkg::cmd_beat_t beat);
        int                  slot;
        ssst_pkg::rsp_beat_t owed;
        slot = slot_of(beat.value);
        owed = '0;
        owed.last = 1'b1;
        case (beat.command)
            ssst_pkg::CMD_INSERT:
            begin
                // A value already held counts as a duplicate, even when the store is full.
                if (slot >= 0)
                    owed.status = ssst_pkg::ST_DUPLICATE;
                else if (held_count >= CAP)
                    owed.status = ssst_pkg::ST_FULL;
                else
                begin
                    held_values[held_count] = beat.value;
                    held_count++;
                    owed.status = ssst_pkg::ST_INSERTED;
                end
            end
            ssst_pkg::CMD_REMOVE:
            begin
                // The last entry moves into the freed slot, so slot order changes.
                if (slot >= 0)
                begin
                    held_values[slot] = held_values[held_count - 1];
                    held_count--;
                    owed.status = ssst_pkg::ST_REMOVED;
                end
                else
                    owed.status = ssst_pkg::ST_NOT_PRESENT;
            end
            ssst_pkg::CMD_LOOKUP:
                owed.status = (slot >= 0) ? ssst_pkg::ST_FOUND : ssst_pkg::ST_ABSENT;
            ssst_pkg::CMD_CLEAR:
            begin
                held_count = 0;
                owed.status = ssst_pkg::ST_CLEARED;
            end
            ssst_pkg::CMD_ITERATE:
            begin
                if (held_count == 0)
                    owed.status = ssst_pkg::ST_EMPTY;
                else
                begin
                    // One element beat for each stored value, in slot order.
                    for (int i = 0; i < held_count; i++)
                    begin
                        owed.status        = ssst_pkg::ST_ELEMENT;
                        owed.element_value = held_values[i];
                        owed.element_count = ssst_pkg::COUNT_W'(held_count);
                        owed.last          = (i == held_count - 1);
                        pending_rsps.push_back(owed);
                    end
                    return;
                end
            end
            default:
                // The spare codes change nothing and produce no response.
                return;
        endcase
        owed.element_count = ssst_pkg::COUNT_W'(held_count);
        pending_rsps.push_back(owed);
    endtask

    // Offers one command beat after a random gap and returns once the block has taken it.
    // Valid is lowered only when a gap follows, so back-to-back beats keep it high.
    task automatic send_command(input logic [2:0] op,
                                input logic signed [ssst_pkg::VALUE_W-1:0] val);
        int                  gap;
        ssst_pkg::cmd_beat_t beat;
        gap = $urandom_range(0, cmd_gap_max);
        beat.command = op;
        beat.value   = val;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= beat;
        do
            @(posedge clk);
        while (!cmd_ready);
        apply_set_command(beat);
    endtask

    // The sender stops and waits until every owed beat has been taken.
    task automatic wait_for_responses();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    // Values come mostly from what is stored or from a small pool, so that the set operations
    // often meet each other; the rest are fully random words.
    function automatic logic signed [ssst_pkg::VALUE_W-1:0] pick_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35 && held_count > 0)
            return held_values[$urandom_range(0, held_count - 1)];
        else if (pick < 80)
            return ssst_pkg::VALUE_W'($urandom_range(0, 79) * 32'h9E37_79B9);
        else
            return $urandom;
    endfunction

    // Receiver: a random stall before each beat, and ready held low while the long hold-off runs.
    initial
    begin
        wait (rst_n);
        forever
        begin
            repeat ($urandom_range(0, rsp_stall_max))
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
            end
            @(negedge clk);
            while (rsp_held)
            begin
                rsp_ready <= 1'b0;
                @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    // Counts out the long hold-off whenever a test asks for one.
    initial
    begin
        forever
        begin
            @(rsp_hold_go);
            @(negedge clk);
            rsp_held <= 1'b1;
            repeat (RSP_HOLD_LEN) @(negedge clk);
            rsp_held <= 1'b0;
        end
    end

    // Checks every response beat that is taken against the oldest beat still owed.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("unexpected response beat: status %0d value %0d count %0d last %0b",
                       rsp.status, rsp.element_value, rsp.element_count, rsp.last);
                mismatch_count++;
            end
            else
            begin
                oldest_rsp = pending_rsps.pop_front();
                if (rsp.status !== oldest_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_rsp.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.element_value !== oldest_rsp.element_value)
                begin
                    $error("element_value: expected %0d, got %0d",
                           oldest_rsp.element_value, rsp.element_value);
                    mismatch_count++;
                end
                if (rsp.element_count !== oldest_rsp.element_count)
                begin
                    $error("element_count: expected %0d, got %0d",
                           oldest_rsp.element_count, rsp.element_count);
                    mismatch_count++;
                end
                if (rsp.last !== oldest_rsp.last)
                begin
                    $error("last: expected %0b, got %0b", oldest_rsp.last, rsp.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Every operation but insert on a store that holds nothing.
    task automatic test_empty_store();
        send_command(ssst_pkg::CMD_ITERATE, 32'sd0);
        send_command(ssst_pkg::CMD_LOOKUP, 32'sd0);
        send_command(ssst_pkg::CMD_REMOVE, 32'sd5);
        send_command(ssst_pkg::CMD_CLEAR, 32'sd0);
    endtask

    // The extremes of the value field, a duplicate, two removals from slot 0 and a removal of a
    // value no longer held, the spare codes, and iterate both before and after a clear.
    task automatic test_extreme_values();
        send_command(ssst_pkg::CMD_INSERT, VAL_MIN);
        send_command(ssst_pkg::CMD_INSERT, VAL_MAX);
        send_command(ssst_pkg::CMD_INSERT, 32'sd0);
        send_command(ssst_pkg::CMD_INSERT, -32'sd1);
        send_command(ssst_pkg::CMD_INSERT, VAL_MAX);
        send_command(ssst_pkg::CMD_LOOKUP, VAL_MIN);
        send_command(ssst_pkg::CMD_LOOKUP, 32'sd1);
        send_command(CMD_SPARE_A, VAL_MAX);
        send_command(ssst_pkg::CMD_ITERATE, 32'sd0);
        send_command(ssst_pkg::CMD_REMOVE, VAL_MIN);
        send_command(CMD_SPARE_B, VAL_MIN);
        send_command(ssst_pkg::CMD_REMOVE, -32'sd1);
        send_command(ssst_pkg::CMD_REMOVE, -32'sd1);
        send_command(CMD_SPARE_C, -32'sd1);
        send_command(ssst_pkg::CMD_ITERATE, 32'sd0);
        send_command(ssst_pkg::CMD_CLEAR, 32'sd0);
        send_command(ssst_pkg::CMD_ITERATE, 32'sd0);
        send_command(ssst_pkg::CMD_LOOKUP, VAL_MAX);
    endtask

    // Fills the store to capacity. The receiver holds off early on, so the block's response
    // path backs up and it has to stall its command input. With the store full, the test then
    // checks a duplicate, a refused insert, a full iterate, and refilling a freed slot.
    task automatic test_fill_to_capacity();
        logic signed [ssst_pkg::VALUE_W-1:0] val;
        wait_for_responses();
        send_command(ssst_pkg::CMD_CLEAR, 32'sd0);
        cmd_gap_max = 0;
        while (held_count < CAP)
        begin
            if (held_count == 4)
                -> rsp_hold_go;
            send_command(ssst_pkg::CMD_INSERT, $urandom);
        end
        cmd_gap_max   = 5;
        send_command(ssst_pkg::CMD_INSERT, held_values[$urandom_range(0, CAP - 1)]);
        do
            val = $urandom;
        while (slot_of(val) >= 0);
        send_command(ssst_pkg::CMD_INSERT, val);
        send_command(ssst_pkg::CMD_LOOKUP, held_values[CAP - 1]);
        send_command(ssst_pkg::CMD_ITERATE, 32'sd0);
        send_command(ssst_pkg::CMD_REMOVE, held_values[0]);
        send_command(ssst_pkg::CMD_INSERT, val);
        send_command(ssst_pkg::CMD_ITERATE, 32'sd0);
        wait_for_responses();
    endtask

    // A long random mix. The idle settings change every forty beats, so that busy and quiet
    // stretches alternate. In the middle the sender drains and pauses, and a second hold-off
    // comes later on.
    task automatic test_random_mix(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++)
        begin
            case ((i / 40) % 3)
                0: begin cmd_gap_max = 5; rsp_stall_max = 5; end
                1: begin cmd_gap_max = 0; rsp_stall_max = 0; end
                default: begin cmd_gap_max = 2; rsp_stall_max = 5; end
            endcase
            if (i == n_items / 2)
                wait_for_responses();
            if (i == (3 * n_items) / 4)
                -> rsp_hold_go;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_command(ssst_pkg::CMD_INSERT, pick_value());
            else if (pick < 63)
                send_command(ssst_pkg::CMD_REMOVE, pick_value());
            else if (pick < 81)
                send_command(ssst_pkg::CMD_LOOKUP, pick_value());
            else if (pick < 88)
                send_command(ssst_pkg::CMD_ITERATE, $urandom);
            else if (pick < 91)
                send_command(ssst_pkg::CMD_CLEAR, $urandom);
            else if (pick < 96)
                send_command(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), $urandom);
            else
                send_command(ssst_pkg::CMD_INSERT, $urandom);
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_extreme_values();
        test_fill_to_capacity();
        test_random_mix(RANDOM_ITEMS);

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_rsps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ssst_pkg.sv
rtl/core/ssst_cell.sv
rtl/core/small_set_store_top.sv
tb/tb_small_set_store_top.sv
